/* hw/rtl/psm_pkg.sv */
`default_nettype none

package psm_pkg;

  localparam int SIG_COUNT   = 9;
  localparam int SIG_MAX_LEN = 20;
  localparam int COUNT_W     = 11;
  localparam int ALERT_W     = 3;
  localparam int PORT_W      = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic [COUNT_W-1:0] SCAN_LIMIT_RST = 11'd1000;
  localparam logic [COUNT_W-1:0] MIN_LENGTH_RST = 11'd54;

  // register indexes
  localparam logic REG_SCAN_LIMIT = 1'b0;
  localparam logic REG_MIN_LENGTH = 1'b1;

  // alert codes
  localparam logic [ALERT_W-1:0] ALERT_NONE   = 3'd0;
  localparam logic [ALERT_W-1:0] ALERT_SQL    = 3'd1;
  localparam logic [ALERT_W-1:0] ALERT_SCRIPT = 3'd2;
  localparam logic [ALERT_W-1:0] ALERT_SHELL  = 3'd3;
  localparam logic [ALERT_W-1:0] ALERT_CRED   = 3'd4;

  // signature groups in the found vector
  localparam logic [SIG_COUNT-1:0] GRP_SQL    = 9'h007;
  localparam logic [SIG_COUNT-1:0] GRP_SCRIPT = 9'h018;
  localparam logic [SIG_COUNT-1:0] GRP_SHELL  = 9'h060;
  localparam logic [SIG_COUNT-1:0] GRP_CRED   = 9'h180;

  localparam logic [PORT_W-1:0] PORT_HTTP     = 16'd80;
  localparam logic [PORT_W-1:0] PORT_HTTP_ALT = 16'd8080;
  localparam logic [PORT_W-1:0] PORT_FTP      = 16'd21;

  typedef struct packed {
    logic [SIG_COUNT-1:0] found;
    logic [COUNT_W-1:0]   count;
    logic [PORT_W-1:0]    port;
  } psm_frame_t;

  // Signature text, lower case, right-justified: bits [7:0] hold the last char.
  function automatic logic [SIG_MAX_LEN*8-1:0] sig_text(input int idx);
    logic [SIG_MAX_LEN*8-1:0] t;
    case (idx)
      0:       t = "union select";
      1:       t = "' or '1'='1";
      2:       t = "drop table";
      3:       t = "<script>";
      4:       t = "javascript:";
      5:       t = "cmd.exe";
      6:       t = "/bin/sh";
      7:       t = "password=";
      8:       t = "authorization: basic";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] sig_len(input int idx);
    logic [4:0] n;
    case (idx)
      0:       n = 5'd12;
      1:       n = 5'd11;
      2:       n = 5'd10;
      3:       n = 5'd8;
      4:       n = 5'd11;
      5:       n = 5'd7;
      6:       n = 5'd7;
      7:       n = 5'd9;
      8:       n = 5'd20;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/psm_window.sv */
`default_nettype none

module psm_window #(
  parameter int WINDOW_BYTES = 20
) (
  input  wire logic                           clk,
  input  wire logic                           step,
  input  wire logic [7:0]                     cur_byte,
  output logic      [psm_pkg::SIG_COUNT-1:0]  hit
);

  localparam int CMP_LEN = (WINDOW_BYTES < psm_pkg::SIG_MAX_LEN) ?
                           WINDOW_BYTES : psm_pkg::SIG_MAX_LEN;

  // win_r[0] is the most recent byte before cur_byte
  logic [7:0] win_r [WINDOW_BYTES-1];

  always_ff @(posedge clk) begin
    if (step) begin
      win_r[0] <= cur_byte;
      for (int j = 1; j < WINDOW_BYTES - 1; j++) begin
        win_r[j] <= win_r[j-1];
      end
    end
  end

  for (genvar i = 0; i < psm_pkg::SIG_COUNT; i++) begin : g_sig
    localparam logic [psm_pkg::SIG_MAX_LEN*8-1:0] TXT = psm_pkg::sig_text(i);
    localparam int LEN = int'(psm_pkg::sig_len(i));
    if (LEN <= WINDOW_BYTES) begin : g_fit
      always_comb begin
        hit[i] = (cur_byte == TXT[7:0]);
        for (int k = 1; k < CMP_LEN; k++) begin
          if (k < LEN) begin
            hit[i] = hit[i] & (win_r[k-1] == TXT[8*k +: 8]);
          end
        end
      end
    end else begin : g_nofit
      assign hit[i] = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psm_alert.sv */
`default_nettype none

module psm_alert (
  input  wire psm_pkg::psm_frame_t                  frame,
  input  wire logic [psm_pkg::COUNT_W-1:0]          min_length,
  output logic      [psm_pkg::ALERT_W-1:0]          alert_code
);

  logic cred_port;

  assign cred_port = (frame.port == psm_pkg::PORT_HTTP) ||
                     (frame.port == psm_pkg::PORT_HTTP_ALT) ||
                     (frame.port == psm_pkg::PORT_FTP);

  always_comb begin
    alert_code = psm_pkg::ALERT_NONE;
    if (frame.count > min_length) begin
      if (|(frame.found & psm_pkg::GRP_SQL)) begin
        alert_code = psm_pkg::ALERT_SQL;
      end else if (|(frame.found & psm_pkg::GRP_SCRIPT)) begin
        alert_code = psm_pkg::ALERT_SCRIPT;
      end else if (|(frame.found & psm_pkg::GRP_SHELL)) begin
        alert_code = psm_pkg::ALERT_SHELL;
      end else if (cred_port && |(frame.found & psm_pkg::GRP_CRED)) begin
        alert_code = psm_pkg::ALERT_CRED;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/payload_signature_matcher_unit.sv */
`default_nettype none

// Payload signature matcher. Takes a frame one byte per beat and flags nine
// case-insensitive text signatures that lie wholly within the first
// scan_limit bytes of the frame. On the final byte one alert_code beat is
// produced (0 none, 1 SQL injection, 2 script injection, 3 remote shell,
// 4 credentials on ports 80/8080/21); the code is 0 unless the frame is
// longer than min_length. Non-final bytes produce no output beat. Throughput
// is one byte per cycle; a final byte goes from the input register, where it
// may stall, into the result register, which then raises out_valid. Input
// ready only drops while a finished result sits unconsumed in the result
// register and the next final byte is already waiting behind it. Configure
// scan_limit (byte 0x0) and min_length (byte 0x4) only while the block is idle.

module payload_signature_matcher_unit #(
  parameter int WINDOW_BYTES = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_frame,
  input  wire logic [15:0] in_dest_port,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_alert_code,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW = psm_pkg::COUNT_W;
  localparam int NS = psm_pkg::SIG_COUNT;

  // ---------------- configuration registers ----------------
  logic [CW-1:0] scan_limit_r;
  logic [CW-1:0] min_length_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= psm_pkg::SCAN_LIMIT_RST;
      min_length_r <= psm_pkg::MIN_LENGTH_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == psm_pkg::REG_SCAN_LIMIT) begin
        scan_limit_r <= cfg_pwdata[CW-1:0];
      end else begin
        min_length_r <= cfg_pwdata[CW-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == psm_pkg::REG_MIN_LENGTH) ?
                      {{(32-CW){1'b0}}, min_length_r} :
                      {{(32-CW){1'b0}}, scan_limit_r};

  // ---------------- input register ----------------
  logic        s1_valid_r;
  logic        s1_last_r;
  logic [7:0]  s1_byte_r;
  logic [15:0] s1_port_r;
  logic [7:0]  folded;
  logic        adv;
  logic        step;
  logic        out_valid_r;
  logic [2:0]  out_alert_r;

  // only A..Z fold to lower case
  assign folded = (in_data_byte >= 8'h41 && in_data_byte <= 8'h5A) ?
                  (in_data_byte + 8'd32) : in_data_byte;

  // stage 1 moves unless it holds a final byte and the result slot is full
  assign adv      = !s1_valid_r || !s1_last_r || !out_valid_r || out_ready;
  assign in_ready = adv;
  assign step     = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_byte_r <= folded;
      s1_last_r <= in_end_of_frame;
      s1_port_r <= in_dest_port;
    end
  end

  // ---------------- match and frame state ----------------
  logic [NS-1:0] hit;
  logic [NS-1:0] pos_ok;
  logic [NS-1:0] flags_r;
  logic [NS-1:0] flags_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW:0]   pos;

  psm_window #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_window (
    .clk      (clk),
    .step     (step),
    .cur_byte (s1_byte_r),
    .hit      (hit)
  );

  assign pos = {1'b0, cnt_r} + {{CW{1'b0}}, 1'b1};

  // a hit counts only if the whole signature sits in this frame and in scan range
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      pos_ok[i] = (pos >= (CW+1)'(psm_pkg::sig_len(i))) && (pos <= {1'b0, scan_limit_r});
    end
  end

  assign flags_nxt = flags_r | (hit & pos_ok);
  assign cnt_nxt   = pos[CW] ? psm_pkg::COUNT_MAX : pos[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      if (s1_last_r) begin
        flags_r <= '0;
        cnt_r   <= '0;
      end else begin
        flags_r <= flags_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // ---------------- alert encode and result register ----------------
  psm_pkg::psm_frame_t frame;
  logic [2:0]          alert_code;

  assign frame.found = flags_nxt;
  assign frame.count = cnt_nxt;
  assign frame.port  = s1_port_r;

  psm_alert u_alert (
    .frame      (frame),
    .min_length (min_length_r),
    .alert_code (alert_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last_r) begin
      out_alert_r <= alert_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alert_code = out_alert_r;

  // ---------------- assertions ----------------
  // a result beat only appears right after a final byte was processed
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step && s1_last_r))
    else $error("result beat without a final byte");

  // frame state is cleared after the final byte
  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_last_r) |=> (cnt_r == '0 && flags_r == '0))
    else $error("frame state not cleared after final byte");

  // input stalls only behind a blocked result with a final byte waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && s1_valid_r && s1_last_r))
    else $error("input stalled without cause");

endmodule

`default_nettype wire

/* dv/psm_checker.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port, keeps its own picture of the
// signature scan and compares every alert beat against it.
module psm_checker #(
  parameter int WINDOW_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_frame,
  input  logic [15:0] in_dest_port,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_alert_code,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatch_count,
  output int          pending
);

  localparam int NUM_SIGS = 9;
  localparam logic [NUM_SIGS-1:0] SQL_SIGS    = 9'b000000111;
  localparam logic [NUM_SIGS-1:0] SCRIPT_SIGS = 9'b000011000;
  localparam logic [NUM_SIGS-1:0] SHELL_SIGS  = 9'b001100000;
  localparam logic [NUM_SIGS-1:0] CRED_SIGS   = 9'b110000000;
  localparam int LEN_SAT = 2047;

  logic [7:0]                  history [WINDOW_BYTES-1];
  logic [NUM_SIGS-1:0]         seen;
  int                          frame_len;
  int                          scan_limit;
  int                          min_length;
  logic [psm_pkg::ALERT_W-1:0] alert_q [$];

  function automatic string sig_pattern(input int idx);
    case (idx)
      0: return "union select";
      1: return "' or '1'='1";
      2: return "drop table";
      3: return "<script>";
      4: return "javascript:";
      5: return "cmd.exe";
      6: return "/bin/sh";
      7: return "password=";
      8: return "authorization: basic";
      default: return "";
    endcase
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // cur is the byte of this beat; older bytes sit in history, newest first
  function automatic bit sig_hit(input int idx, input logic [7:0] cur, input int pos);
    string pat;
    int n;
    logic [7:0] have;
    pat = sig_pattern(idx);
    n = pat.len();
    if (n > WINDOW_BYTES || pos < n || pos > scan_limit) return 0;
    for (int k = 0; k < n; k++) begin
      have = (k == 0) ? cur : history[k-1];
      if (have != pat[n-1-k]) return 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : scan
    logic [7:0] b;
    logic [psm_pkg::ALERT_W-1:0] code;
    logic [psm_pkg::ALERT_W-1:0] want;
    int pos;
    if (!rst_n) begin
      for (int j = 0; j < WINDOW_BYTES-1; j++) history[j] = 8'h00;
      seen = '0;
      frame_len = 0;
      scan_limit = 1000;
      min_length = 54;
      alert_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == psm_pkg::REG_SCAN_LIMIT) scan_limit = cfg_pwdata[10:0];
        else scan_limit = scan_limit;
        if (cfg_paddr[2] == psm_pkg::REG_MIN_LENGTH) min_length = cfg_pwdata[10:0];
      end

      if (in_valid && in_ready) begin
        b = fold_case(in_data_byte);
        pos = frame_len + 1;
        for (int i = 0; i < NUM_SIGS; i++)
          if (sig_hit(i, b, pos)) seen[i] = 1'b1;
        for (int j = WINDOW_BYTES-2; j > 0; j--) history[j] = history[j-1];
        history[0] = b;
        frame_len = (pos > LEN_SAT) ? LEN_SAT : pos;

        if (in_end_of_frame) begin
          code = psm_pkg::ALERT_NONE;
          if (frame_len > min_length) begin
            if (|(seen & SQL_SIGS))         code = psm_pkg::ALERT_SQL;
            else if (|(seen & SCRIPT_SIGS)) code = psm_pkg::ALERT_SCRIPT;
            else if (|(seen & SHELL_SIGS))  code = psm_pkg::ALERT_SHELL;
            else if ((in_dest_port == 16'd80 || in_dest_port == 16'd8080 ||
                      in_dest_port == 16'd21) && |(seen & CRED_SIGS))
              code = psm_pkg::ALERT_CRED;
          end
          alert_q.push_back(code);
          seen = '0;
          frame_len = 0;
        end
      end

      if (out_valid && out_ready) begin
        if (alert_q.size() == 0) begin
          report_mismatch($sformatf("alert beat %0d with no frame pending", out_alert_code));
        end else begin
          want = alert_q.pop_front();
          if (out_alert_code !== want)
            report_mismatch($sformatf("alert_code got %0d want %0d", out_alert_code, want));
        end
      end
    end
    pending = alert_q.size();
  end

endmodule

/* dv/payload_signature_matcher_unit_test.sv */
`timescale 1ns / 1ps

// Drives frames into the matcher, one byte per beat, and lets the checker
// judge the alert beats. The run walks through several register settings;
// registers are only touched once every expected alert has come back.
module payload_signature_matcher_unit_test;

  localparam int SEG_ITEMS   = 250;   // random bytes per register setting
  localparam int NUM_SEGS    = 7;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int STALL_LIMIT = 4000;  // cycles without any beat
  localparam int MAX_GAP     = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_frame = 1'b0;
  logic [15:0] in_dest_port = 16'h0000;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_alert_code;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatch_count;
  int pending;

  // idling percentages, set per phase by the stimulus
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          sent = 0;
  int          quiet_cycles = 0;

  logic [7:0] frame_buf [$];

  payload_signature_matcher_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .in_dest_port    (in_dest_port),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_alert_code  (out_alert_code),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  psm_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .in_dest_port    (in_dest_port),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_alert_code  (out_alert_code),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .pending         (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: any beat on either channel or a register access resets it.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. Ready drops at random per the current percentage; on request it
  // holds off for a long stretch so final bytes pile up and in_ready drops.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // One input beat. Called at a rising edge; returns at the edge that took it.
  // Ready is looked at on the falling edge so the sample never races the
  // block's own update.
  task automatic send_byte(input logic [7:0] data, input logic eof, input logic [15:0] port);
    int gaps;
    gaps = 0;
    while (gaps < MAX_GAP && $urandom_range(99, 0) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_end_of_frame <= eof;
    in_dest_port    <= port;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  // Stop offering, then wait out every pending alert plus the two-stage pipe.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then an idle cycle so psel never toggles twice
  // in the same step. Upper data bits are junk on purpose.
  task automatic cfg_write(input logic sel, input logic [10:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= ($urandom() & 32'hFFFF_F800) | {21'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic [15:0] port);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], k == s.len() - 1, port);
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if ($urandom_range(1, 0)) begin
      c = $urandom_range(255, 0);
    end else begin
      c = 8'h61 + $urandom_range(25, 0);
      if ($urandom_range(1, 0)) c = c & 8'hDF;
    end
    return c;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(5, 0))
      0:       return psm_pkg::PORT_HTTP;
      1:       return psm_pkg::PORT_HTTP_ALT;
      2:       return psm_pkg::PORT_FTP;
      3:       return $urandom_range(1, 0) ? psm_pkg::PORT_HTTP + 16'd1 :
                                             psm_pkg::PORT_FTP - 16'd1;
      default: return $urandom_range(65535, 0);
    endcase
  endfunction

  task automatic fill_buf(input int n);
    frame_buf.delete();
    for (int k = 0; k < n; k++) frame_buf.push_back(filler_byte());
  endtask

  // Drop signature idx into the buffer at offset at, letters in random case.
  task automatic plant_sig(input int idx, input int at);
    logic [psm_pkg::SIG_MAX_LEN*8-1:0] txt;
    int n;
    logic [7:0] c;
    txt = psm_pkg::sig_text(idx);
    n = psm_pkg::sig_len(idx);
    for (int k = 0; k < n; k++) begin
      c = txt[(n-1-k)*8 +: 8];
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1, 0)) c = c & 8'hDF;
      frame_buf[at+k] = c;
    end
  endtask

  // Non-final beats carry a junk port; only the final one matters.
  task automatic send_buf(input logic [15:0] port);
    for (int k = 0; k < frame_buf.size(); k++) begin
      if (k == frame_buf.size() - 1) send_byte(frame_buf[k], 1'b1, port);
      else send_byte(frame_buf[k], 1'b0, $urandom_range(65535, 0));
    end
  endtask

  // Random frame: mostly short, a few long enough to clear min_length, with
  // zero to three signatures planted and some of them damaged by a bit flip.
  task automatic random_frame();
    int flen;
    int plants;
    int idx;
    int n;
    int at;
    int r;
    r = $urandom_range(99, 0);
    if (r < 55)      flen = $urandom_range(30, 1);
    else if (r < 85) flen = $urandom_range(70, 31);
    else             flen = $urandom_range(130, 71);
    fill_buf(flen);
    plants = $urandom_range(3, 0);
    for (int p = 0; p < plants; p++) begin
      idx = $urandom_range(psm_pkg::SIG_COUNT-1, 0);
      n = psm_pkg::sig_len(idx);
      if (n > flen) continue;
      at = $urandom_range(flen - n, 0);
      plant_sig(idx, at);
      if ($urandom_range(3, 0) == 0)
        frame_buf[at + $urandom_range(n-1, 0)] ^= (8'h01 << $urandom_range(7, 0));
    end
    send_buf(pick_port());
  endtask

  // Frame past the count saturation point: a credentials hit early on and an
  // SQL hit whose last byte lands right around the 2047 boundary.
  task automatic long_frame();
    int idx;
    int last_pos;
    fill_buf(2060);
    plant_sig(7, 100);
    idx = $urandom_range(2, 0);
    last_pos = $urandom_range(2052, 2040);
    plant_sig(idx, last_pos - psm_pkg::sig_len(idx));
    send_buf(psm_pkg::PORT_HTTP);
  endtask

  initial begin
    logic [10:0] scan_val;
    logic [10:0] min_val;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      // first two settings: slow receiver, then slow sender, then no idling
      if (seg < 2) begin
        send_idle_pct = 6;
        recv_idle_pct = 77;
      end else if (seg < 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (seg)
        0:       begin scan_val = 11'd2047; min_val = 11'd0;    end
        1:       begin scan_val = 11'd1000; min_val = 11'd54;   end
        2:       begin scan_val = 11'd25;   min_val = 11'd12;   end
        3:       begin scan_val = 11'd1;    min_val = 11'd0;    end
        4:       begin scan_val = 11'd2047; min_val = 11'd2047; end
        5:       begin scan_val = 11'd40;   min_val = 11'd20;   end
        default: begin scan_val = 11'd0;    min_val = 11'd5;    end
      endcase
      drain();
      cfg_write(psm_pkg::REG_SCAN_LIMIT, scan_val);
      cfg_write(psm_pkg::REG_MIN_LENGTH, min_val);

      if (seg == 0) begin
        // directed frames: case folding, a signature cut by a frame boundary,
        // credentials on an allowed port, one all-ones beat and a long frame
        send_text("<ScRiPt>", psm_pkg::PORT_HTTP);
        send_text("/bin/", 16'd0);
        send_text("sh", psm_pkg::PORT_FTP);
        send_text("PASSWORD=", psm_pkg::PORT_HTTP_ALT);
        send_byte(8'hFF, 1'b1, 16'hFFFF);
        long_frame();
      end

      // short frames with no idling fill the pipe while the receiver sits out
      if (seg == 5) hold_req = 1'b1;

      sent = 0;
      while (sent < SEG_ITEMS) random_frame();
    end

    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
